### rtl/mhcp_pkg.sv
// ----------------------------------------------------------------------------
// mhcp_pkg: shared types and constants for the multihop swap profit block
// Widths of the Q32.16 amounts, the product accumulator and the sequencer states.
// ----------------------------------------------------------------------------
package mhcp_pkg;

  localparam int AMT_W   = 48;             // unsigned Q32.16 amount
  localparam int FEE_W   = 16;             // unsigned Q0.16 fee
  localparam int KEEP_W  = FEE_W + 1;      // 1 - fee, Q1.16
  localparam int HALF_W  = AMT_W / 2;      // operand width of the shared multiplier
  localparam int ACC_W   = 2 * AMT_W;      // full product width
  localparam int DEN_W   = AMT_W + 1;      // reserve_in + net
  localparam int PROF_W  = AMT_W + 2;      // signed Q33.16 profit
  localparam int HOP_W   = 4;
  localparam int CNT_W   = 6;
  localparam int DIV_STEPS = AMT_W;
  localparam int NET_STEPS = 2;
  localparam int MUL_STEPS = 4;

  localparam int IN_DATA_W  = 3 * AMT_W + FEE_W;
  localparam int OUT_DATA_W = ((PROF_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NET,
    S_MUL,
    S_CHK,
    S_DIV,
    S_END
  } state_t;

endpackage

### rtl/multihop_constant_product_profit.sv
// ----------------------------------------------------------------------------
// multihop_constant_product_profit: swap route profit evaluator
// Applies constant-product swaps hop by hop and reports route profit.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser / tlast
//  in_     | in  | start_amount, pool_rsv_in,                  | tuser: route_start,
//          |     | pool_rsv_out, swap_fee                      |   has_hop; tlast: route_end
//  out_    | out | route_profit (signed, zero filled)          | tuser: amount_saturated
//  cfg_    | in  | exec_fee                                    | -
//
//  an item without a swap only takes the beat, then the result if it ends the
//  route; a swap hop takes the beat, forms net, forms the product, runs a check
//  and 48 divide steps (a saturating hop skips the divide), then the result if it
//  ends the route; all on one 24x24 multiplier and one 50-bit compare-subtract unit
//  in_tready is low while an item is being worked on; a finished result sits in
//  the output register, so the next item is taken while out_tvalid waits, and a
//  route end only stalls while that register is still full
//  synchronous active-low reset clears route state and the fee register
// ----------------------------------------------------------------------------
module multihop_constant_product_profit
  import mhcp_pkg::*;
#(
  parameter int MAX_HOPS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_amount, pool_rsv_in, pool_rsv_out, swap_fee
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // route_start, has_hop
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // route_profit, zero filled
  output logic [OUT_DATA_W-1:0] out_tdata,
  // amount_saturated
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [AMT_W-1:0]      cfg_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [AMT_W-1:0]   run_r, run_nxt;
  logic [AMT_W-1:0]   init_r, init_nxt;
  logic [HOP_W-1:0]   hops_r, hops_nxt;
  logic               sat_r, sat_nxt;
  logic [AMT_W-1:0]   fee_r;
  logic [KEEP_W-1:0]  keep_r, keep_nxt;
  logic [AMT_W-1:0]   rin_r, rin_nxt;
  logic [AMT_W-1:0]   rout_r, rout_nxt;
  logic [AMT_W-1:0]   net_r, net_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic               end_r, end_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PROF_W-1:0]  out_data_r, out_data_nxt;
  logic               out_sat_r, out_sat_nxt;

  // shared multiplier and divide step
  logic [HALF_W-1:0]  mul_a, mul_b;
  logic [AMT_W-1:0]   mul_p;
  logic [1:0]         mul_sh;
  logic [ACC_W-1:0]   mac_sum;
  logic [DEN_W:0]     trial, diff;
  logic               q_bit;
  logic [DEN_W-1:0]   den_sum;
  logic               in_beat, do_hop, last_net, last_mul, last_div;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-PROF_W){1'b0}}, out_data_r};
  assign out_tuser  = out_sat_r;

  assign last_net = (cnt_r == CNT_W'(NET_STEPS - 1));
  assign last_mul = (cnt_r == CNT_W'(MUL_STEPS - 1));
  assign last_div = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // operand selection: net = amount * keep, then product = rout * net
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = 2'd0;
    if (state_r == S_NET) begin
      mul_a  = cnt_r[0] ? run_r[AMT_W-1:HALF_W] : run_r[HALF_W-1:0];
      mul_b  = HALF_W'(keep_r);
      mul_sh = {1'b0, cnt_r[0]};
    end else begin
      mul_a  = cnt_r[1] ? rout_r[AMT_W-1:HALF_W] : rout_r[HALF_W-1:0];
      mul_b  = cnt_r[0] ? net_r[AMT_W-1:HALF_W] : net_r[HALF_W-1:0];
      mul_sh = 2'(cnt_r[1]) + 2'(cnt_r[0]);
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (mul_sh)
      2'd0:    mac_sum = acc_r + {{(ACC_W-AMT_W){1'b0}}, mul_p};
      2'd1:    mac_sum = acc_r + {{(ACC_W-AMT_W-HALF_W){1'b0}}, mul_p, {HALF_W{1'b0}}};
      default: mac_sum = acc_r + {mul_p, {(ACC_W-AMT_W){1'b0}}};
    endcase
  end

  assign trial   = {rem_r, acc_r[AMT_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign q_bit   = (trial >= {1'b0, den_r});
  assign den_sum = {1'b0, rin_r} + {1'b0, net_r};

  always_comb begin
    do_hop = in_tuser[1] && (in_tuser[0] || (hops_r < HOP_W'(MAX_HOPS)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      run_r       <= '0;
      init_r      <= '0;
      hops_r      <= '0;
      sat_r       <= 1'b0;
      fee_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      run_r       <= run_nxt;
      init_r      <= init_nxt;
      hops_r      <= hops_nxt;
      sat_r       <= sat_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        fee_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    keep_r     <= keep_nxt;
    rin_r      <= rin_nxt;
    rout_r     <= rout_nxt;
    net_r      <= net_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    run_nxt       = run_r;
    init_nxt      = init_r;
    hops_nxt      = hops_r;
    sat_nxt       = sat_r;
    keep_nxt      = keep_r;
    rin_nxt       = rin_r;
    rout_nxt      = rout_r;
    net_nxt       = net_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_tuser[0]) begin
            run_nxt  = in_tdata[AMT_W-1:0];
            init_nxt = in_tdata[AMT_W-1:0];
            hops_nxt = '0;
            sat_nxt  = 1'b0;
          end
          rin_nxt  = in_tdata[2*AMT_W-1:AMT_W];
          rout_nxt = in_tdata[3*AMT_W-1:2*AMT_W];
          keep_nxt = KEEP_W'(1 << FEE_W) - {1'b0, in_tdata[IN_DATA_W-1:3*AMT_W]};
          end_nxt  = in_tlast;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          if (do_hop) begin
            state_nxt = S_NET;
          end else if (in_tlast) begin
            state_nxt = S_END;
          end
        end
      end

      S_NET: begin
        acc_nxt = mac_sum;
        cnt_nxt = cnt_r + 1'b1;
        if (last_net) begin
          net_nxt   = mac_sum[AMT_W+FEE_W-1:FEE_W];
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        acc_nxt = mac_sum;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          // zero denominator only when net is zero: raise to one lsb
          den_nxt = (den_sum == '0) ? DEN_W'(1) : den_sum;
        end
        if (last_mul) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        // upper half of the product below the divisor keeps the quotient in 48 bits
        if ({1'b0, acc_r[ACC_W-1:AMT_W]} >= den_r) begin
          run_nxt   = '1;
          sat_nxt   = 1'b1;
          hops_nxt  = hops_r + 1'b1;
          state_nxt = end_r ? S_END : S_IDLE;
        end else begin
          rem_nxt   = {1'b0, acc_r[ACC_W-1:AMT_W]};
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        acc_nxt = {acc_r[ACC_W-1:AMT_W], acc_r[AMT_W-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (last_div) begin
          run_nxt   = {acc_r[AMT_W-2:0], q_bit};
          hops_nxt  = hops_r + 1'b1;
          state_nxt = end_r ? S_END : S_IDLE;
        end
      end

      S_END: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {2'b00, run_r} - {2'b00, init_r} - {2'b00, fee_r};
          out_sat_nxt   = sat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // divide remainder always stays below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("divide remainder not below divisor");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide step count overrun");

  a_hop_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hops_r <= HOP_W'(MAX_HOPS))
    else $error("hop count beyond limit");

  // a new result beat only comes out of the route end state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_END))
    else $error("result raised outside route end");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_MUL) |=> !in_tready || $past(last_div))
    else $error("input taken while hop in progress");

endmodule
